### rtl/morse_run_length_decoder_macros.svh
// Assertion macros for the Morse run-length decoder.
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef MORSE_RUN_LENGTH_DECODER_MACROS_SVH
`define MORSE_RUN_LENGTH_DECODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MRLD_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MRLD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/mrld_pkg.sv
// Shared constants and types of the Morse run-length decoder.
// No dependencies; used by mrld_code_rom and morse_run_length_decoder.
`default_nettype none

package mrld_pkg;

    localparam int COUNT_BITS   = 10;
    localparam int MAX_ELEMENTS = 5;

    localparam int SAMPLE_W = 12;
    localparam int LEN_W    = 10;
    localparam int CFG_W    = 12;
    localparam int CHAR_W   = 7;
    localparam int ELEM_W   = MAX_ELEMENTS;
    localparam int CNT_W    = $clog2(MAX_ELEMENTS + 2);
    localparam int CMP_W    = (COUNT_BITS > LEN_W) ? COUNT_BITS : LEN_W;

    localparam logic [COUNT_BITS-1:0] RUN_MAX  = {COUNT_BITS{1'b1}};
    localparam logic [CNT_W-1:0]      TOO_LONG = CNT_W'(MAX_ELEMENTS + 1);
    localparam logic [CNT_W-1:0]      CNT_FULL = CNT_W'(MAX_ELEMENTS);

    localparam logic [CHAR_W-1:0] ASCII_SPACE = 7'h20;

    // Configuration register indexes
    localparam logic [1:0] REG_ON_THRESHOLD    = 2'd0;
    localparam logic [1:0] REG_DOT_LENGTH      = 2'd1;
    localparam logic [1:0] REG_DASH_LENGTH     = 2'd2;
    localparam logic [1:0] REG_WORD_GAP_LENGTH = 2'd3;

    typedef struct packed {
        logic              hit;
        logic [CHAR_W-1:0] character;
    } lookup_t;

endpackage

`default_nettype wire

### rtl/mrld_code_rom.sv
// Code table: maps a collected Morse code (element i in bit i, 1 = dash)
// to its ASCII letter or digit. Depends on mrld_pkg.
`default_nettype none

module mrld_code_rom
    import mrld_pkg::*;
(
    input  wire logic [CNT_W-1:0]  code_count,
    input  wire logic [ELEM_W-1:0] code_elements,
    output lookup_t                result
);

    logic [CHAR_W-1:0] ch;

    always_comb
    begin
        ch = '0;
        case (code_count)
            CNT_W'(1):
            begin
                case (code_elements)
                    ELEM_W'(5'b00000): ch = 7'h45; // E
                    ELEM_W'(5'b00001): ch = 7'h54; // T
                    default:           ch = '0;
                endcase
            end
            CNT_W'(2):
            begin
                case (code_elements)
                    ELEM_W'(5'b00010): ch = 7'h41; // A
                    ELEM_W'(5'b00000): ch = 7'h49; // I
                    ELEM_W'(5'b00011): ch = 7'h4D; // M
                    ELEM_W'(5'b00001): ch = 7'h4E; // N
                    default:           ch = '0;
                endcase
            end
            CNT_W'(3):
            begin
                case (code_elements)
                    ELEM_W'(5'b00001): ch = 7'h44; // D
                    ELEM_W'(5'b00011): ch = 7'h47; // G
                    ELEM_W'(5'b00101): ch = 7'h4B; // K
                    ELEM_W'(5'b00111): ch = 7'h4F; // O
                    ELEM_W'(5'b00010): ch = 7'h52; // R
                    ELEM_W'(5'b00000): ch = 7'h53; // S
                    ELEM_W'(5'b00100): ch = 7'h55; // U
                    ELEM_W'(5'b00110): ch = 7'h57; // W
                    default:           ch = '0;
                endcase
            end
            CNT_W'(4):
            begin
                case (code_elements)
                    ELEM_W'(5'b00001): ch = 7'h42; // B
                    ELEM_W'(5'b00101): ch = 7'h43; // C
                    ELEM_W'(5'b00100): ch = 7'h46; // F
                    ELEM_W'(5'b00000): ch = 7'h48; // H
                    ELEM_W'(5'b01110): ch = 7'h4A; // J
                    ELEM_W'(5'b00010): ch = 7'h4C; // L
                    ELEM_W'(5'b00110): ch = 7'h50; // P
                    ELEM_W'(5'b01011): ch = 7'h51; // Q
                    ELEM_W'(5'b01000): ch = 7'h56; // V
                    ELEM_W'(5'b01001): ch = 7'h58; // X
                    ELEM_W'(5'b01101): ch = 7'h59; // Y
                    ELEM_W'(5'b00011): ch = 7'h5A; // Z
                    default:           ch = '0;
                endcase
            end
            CNT_W'(5):
            begin
                case (code_elements)
                    ELEM_W'(5'b11111): ch = 7'h30;
                    ELEM_W'(5'b11110): ch = 7'h31;
                    ELEM_W'(5'b11100): ch = 7'h32;
                    ELEM_W'(5'b11000): ch = 7'h33;
                    ELEM_W'(5'b10000): ch = 7'h34;
                    ELEM_W'(5'b00000): ch = 7'h35;
                    ELEM_W'(5'b00001): ch = 7'h36;
                    ELEM_W'(5'b00011): ch = 7'h37;
                    ELEM_W'(5'b00111): ch = 7'h38;
                    ELEM_W'(5'b01111): ch = 7'h39;
                    default:           ch = '0;
                endcase
            end
            default: ch = '0;
        endcase
    end

    assign result.hit       = (ch != '0);
    assign result.character = ch;

endmodule

`default_nettype wire

### rtl/morse_run_length_decoder.sv
// Morse run-length decoder: one sample item per clock in, one ASCII character
// item out per recognised letter or word gap. An accepted sample lands in an
// input register and is decoded against the run counters and the code table once
// the output register is free or being read; a character then lands in the
// output register, which drives character_valid.
// The block takes one sample every cycle; the only stall comes from a character
// held in the output register while the consumer is not ready.
// Depends on mrld_pkg, mrld_code_rom and morse_run_length_decoder_macros.svh.
`default_nettype none

`include "morse_run_length_decoder_macros.svh"

module morse_run_length_decoder
    import mrld_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [CFG_W-1:0]    cfg_data,
    input  wire logic                sample_valid,
    output      logic                sample_ready,
    input  wire logic [SAMPLE_W-1:0] sample,
    output      logic                character_valid,
    input  wire logic                character_ready,
    output      logic [CHAR_W-1:0]   character
);

    logic [SAMPLE_W-1:0]   on_threshold_reg;
    logic [LEN_W-1:0]      dot_length_reg;
    logic [LEN_W-1:0]      dash_length_reg;
    logic [LEN_W-1:0]      word_gap_length_reg;

    logic                  s1_valid_reg, s1_valid_next;
    logic [SAMPLE_W-1:0]   sample_reg;

    logic [COUNT_BITS-1:0] on_run_reg, on_run_next;
    logic [COUNT_BITS-1:0] off_run_reg, off_run_next;
    logic [ELEM_W-1:0]     code_elements_reg, code_elements_next;
    logic [CNT_W-1:0]      code_count_reg, code_count_next;
    logic                  dot_in_run_reg, dot_in_run_next;

    logic                  out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]     char_reg, char_next;

    logic                  accept;
    logic                  fire;
    logic                  is_on;
    logic                  emit;
    logic [COUNT_BITS-1:0] on_inc;
    logic [COUNT_BITS-1:0] off_inc;
    logic                  on_dash_hit, on_dot_hit, off_letter_hit, off_word_hit;
    logic [CNT_W-1:0]      app_count;
    logic [ELEM_W-1:0]     app_elem_dash;
    logic [ELEM_W-1:0]     mark_elem;
    lookup_t               lookup;

    mrld_code_rom u_code_rom (
        .code_count    (code_count_reg),
        .code_elements (code_elements_reg),
        .result        (lookup)
    );

    assign fire         = s1_valid_reg && (!out_valid_reg || character_ready);
    assign sample_ready = !s1_valid_reg || fire;
    assign accept       = sample_valid && sample_ready;

    assign is_on   = (sample_reg > on_threshold_reg);
    assign on_inc  = on_run_reg + COUNT_BITS'(1);
    assign off_inc = off_run_reg + COUNT_BITS'(1);

    // A length fires only when the counter steps onto it; zero never matches
    assign on_dash_hit    = (dash_length_reg != '0)
                         && (CMP_W'(on_inc) == CMP_W'(dash_length_reg));
    assign on_dot_hit     = (dot_length_reg != '0)
                         && (CMP_W'(on_inc) == CMP_W'(dot_length_reg));
    assign off_letter_hit = (dash_length_reg != '0)
                         && (CMP_W'(off_inc) == CMP_W'(dash_length_reg));
    assign off_word_hit   = (word_gap_length_reg != '0)
                         && (CMP_W'(off_inc) == CMP_W'(word_gap_length_reg));

    // Append one element, or mark the code too long when full
    always_comb
    begin
        app_count     = TOO_LONG;
        app_elem_dash = code_elements_reg;
        if (code_count_reg < CNT_FULL)
        begin
            app_count = code_count_reg + CNT_W'(1);
            for (int i = 0; i < ELEM_W; i++)
            begin
                if (code_count_reg == CNT_W'(i))
                begin
                    app_elem_dash[i] = 1'b1;
                end
            end
        end
    end

    // Turn the last recorded dot into a dash
    always_comb
    begin
        mark_elem = code_elements_reg;
        if ((code_count_reg != '0) && (code_count_reg <= CNT_FULL))
        begin
            for (int i = 0; i < ELEM_W; i++)
            begin
                if (code_count_reg == CNT_W'(i + 1))
                begin
                    mark_elem[i] = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        on_run_next        = on_run_reg;
        off_run_next       = off_run_reg;
        code_elements_next = code_elements_reg;
        code_count_next    = code_count_reg;
        dot_in_run_next    = dot_in_run_reg;
        emit               = 1'b0;
        char_next          = char_reg;

        if (is_on)
        begin
            off_run_next = '0;
            if (on_run_reg != RUN_MAX)
            begin
                on_run_next = on_inc;
                if (on_dash_hit)
                begin
                    if (dot_in_run_reg)
                    begin
                        code_elements_next = mark_elem;
                        dot_in_run_next    = 1'b0;
                    end
                    else
                    begin
                        code_elements_next = app_elem_dash;
                        code_count_next    = app_count;
                    end
                end
                else if (on_dot_hit)
                begin
                    code_count_next = app_count;
                    dot_in_run_next = 1'b1;
                end
            end
        end
        else
        begin
            on_run_next     = '0;
            dot_in_run_next = 1'b0;
            if (off_run_reg != RUN_MAX)
            begin
                off_run_next = off_inc;
                if (off_letter_hit)
                begin
                    code_elements_next = '0;
                    code_count_next    = '0;
                    emit               = lookup.hit;
                    char_next          = lookup.character;
                end
                else if (off_word_hit)
                begin
                    emit      = 1'b1;
                    char_next = ASCII_SPACE;
                end
            end
        end
    end

    assign s1_valid_next  = accept ? 1'b1 : (fire ? 1'b0 : s1_valid_reg);
    assign out_valid_next = fire ? emit : (out_valid_reg && !character_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_threshold_reg    <= SAMPLE_W'(2048);
            dot_length_reg      <= LEN_W'(3);
            dash_length_reg     <= LEN_W'(9);
            word_gap_length_reg <= LEN_W'(21);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ON_THRESHOLD:    on_threshold_reg    <= cfg_data[SAMPLE_W-1:0];
                REG_DOT_LENGTH:      dot_length_reg      <= cfg_data[LEN_W-1:0];
                REG_DASH_LENGTH:     dash_length_reg     <= cfg_data[LEN_W-1:0];
                REG_WORD_GAP_LENGTH: word_gap_length_reg <= cfg_data[LEN_W-1:0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            on_run_reg        <= '0;
            off_run_reg       <= '0;
            code_elements_reg <= '0;
            code_count_reg    <= '0;
            dot_in_run_reg    <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                on_run_reg        <= on_run_next;
                off_run_reg       <= off_run_next;
                code_elements_reg <= code_elements_next;
                code_count_reg    <= code_count_next;
                dot_in_run_reg    <= dot_in_run_next;
            end
        end
    end

    // Payload registers: hold while stalled
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= sample;
        end
        if (fire && emit)
        begin
            char_reg <= char_next;
        end
    end

    assign character_valid = out_valid_reg;
    assign character       = char_reg;

    `MRLD_ASSERT_IMPLY(a_count_range, 1'b1, code_count_reg <= TOO_LONG, "code count out of range")
    `MRLD_ASSERT_IMPLY(a_runs_exclusive, on_run_reg != '0, off_run_reg == '0, "both runs active")
    `MRLD_ASSERT_IMPLY(a_dot_in_on_run, dot_in_run_reg, on_run_reg != '0, "dot flag outside ON run")
    `MRLD_ASSERT_NEXT(a_no_emit_on_on, fire && is_on, out_valid_reg == 1'b0, "character on ON item")

endmodule

`default_nettype wire
